// File: src/heater_temperature_alert_monitor_top_assert.svh
// Assertion macros for the heater temperature alert monitor.
// Included by the checker module; needs nothing else.
`ifndef HEATER_TEMPERATURE_ALERT_MONITOR_TOP_ASSERT_SVH
`define HEATER_TEMPERATURE_ALERT_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define HTAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("htam assertion failed");

// Next-cycle implication, disabled while reset is low
`define HTAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("htam assertion failed");

`endif

// File: src/htam_pkg.sv
// Shared types and constants for the heater temperature alert monitor.
// No dependencies.
`timescale 1ns / 1ps

package htam_pkg;

	// APB address and data widths
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Field widths
	localparam int TEMP_W   = 11;
	localparam int SETPT_W  = 8;
	localparam int WIN_W    = 6;
	localparam int MARGIN_W = 8;

	// Reset values of the registers and state
	localparam logic [SETPT_W-1:0]         SET_TEMP_RST  = 8'd50;
	localparam logic [WIN_W-1:0]           WINDOW_RST    = 6'd3;
	localparam logic [WIN_W-1:0]           HYST_RST      = 6'd2;
	localparam logic [MARGIN_W-1:0]        MARGIN_RST    = 8'd10;
	localparam logic signed [TEMP_W-1:0]   REF_TEMP_RST  = 11'sd1023;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SET_TEMP = 2'd0,
		REG_WINDOW   = 2'd1,
		REG_HYST     = 2'd2,
		REG_MARGIN   = 2'd3
	} htam_reg_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [SETPT_W-1:0]  set_temperature;
		logic [WIN_W-1:0]    alert_window;
		logic [WIN_W-1:0]    alert_hysteresis;
		logic [MARGIN_W-1:0] rise_margin;
	} htam_cfg_t;

	// One input sample
	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic                     sensor_fault;
		logic                     heater_on;
		logic                     calibrating;
		logic                     ten_second_tick;
	} htam_item_t;

	// One result
	typedef struct packed {
		logic sensor_alert;
		logic reached_alert;
		logic runaway_alert;
		logic force_sound;
	} htam_res_t;

endpackage

// File: src/heater_temperature_alert_monitor_top.sv
// Heater temperature alert monitor, top level.
// The sample is registered in the input stage, and its result in the result stage.
// Throughput: one sample per cycle unless out_stall holds the result stage; the input register
// and result register each hold one beat, and the window/reference state is registered.
// Reset (arst_n low, asynchronous): both stages empty, registers at defaults,
// narrow window, reference temperature 1023.
`timescale 1ns / 1ps

module heater_temperature_alert_monitor_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [htam_pkg::ADDR_W-1:0]       paddr,
	input  logic [htam_pkg::DATA_W-1:0]       pwdata,
	output logic [htam_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// Sample input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [htam_pkg::TEMP_W-1:0] temperature,
	input  logic                              sensor_fault,
	input  logic                              heater_on,
	input  logic                              calibrating,
	input  logic                              ten_second_tick,
	// Alert output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              sensor_alert,
	output logic                              reached_alert,
	output logic                              runaway_alert,
	output logic                              force_sound
);
	import htam_pkg::*;

	htam_cfg_t  cfg;
	htam_item_t item_s1;
	logic       valid_s1;
	htam_res_t  res;
	htam_res_t  res_s2;
	logic       valid_s2;
	logic       adv_s2;
	logic       adv_s1;
	logic       load_s1;

	htam_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline flow: result stage frees when empty or its beat is taken
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.temperature     <= temperature;
			item_s1.sensor_fault    <= sensor_fault;
			item_s1.heater_on       <= heater_on;
			item_s1.calibrating     <= calibrating;
			item_s1.ten_second_tick <= ten_second_tick;
		end
	end

	htam_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (adv_s1),
		.res     (res)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign sensor_alert  = res_s2.sensor_alert;
	assign reached_alert = res_s2.reached_alert;
	assign runaway_alert = res_s2.runaway_alert;
	assign force_sound   = res_s2.force_sound;

endmodule

// File: src/htam_regs.sv
// APB configuration registers of the heater temperature alert monitor.
// Depends on htam_pkg.
`timescale 1ns / 1ps

module htam_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [htam_pkg::ADDR_W-1:0]    paddr,
	input  logic [htam_pkg::DATA_W-1:0]    pwdata,
	output logic [htam_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output htam_pkg::htam_cfg_t            cfg
);
	import htam_pkg::*;

	htam_cfg_t cfg_q;
	htam_reg_t reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_sel = htam_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_temperature  <= SET_TEMP_RST;
			cfg_q.alert_window     <= WINDOW_RST;
			cfg_q.alert_hysteresis <= HYST_RST;
			cfg_q.rise_margin      <= MARGIN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SET_TEMP: cfg_q.set_temperature  <= pwdata[SETPT_W-1:0];
				REG_WINDOW:   cfg_q.alert_window     <= pwdata[WIN_W-1:0];
				REG_HYST:     cfg_q.alert_hysteresis <= pwdata[WIN_W-1:0];
				REG_MARGIN:   cfg_q.rise_margin      <= pwdata[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_SET_TEMP: prdata[SETPT_W-1:0]  = cfg_q.set_temperature;
			REG_WINDOW:   prdata[WIN_W-1:0]    = cfg_q.alert_window;
			REG_HYST:     prdata[WIN_W-1:0]    = cfg_q.alert_hysteresis;
			REG_MARGIN:   prdata[MARGIN_W-1:0] = cfg_q.rise_margin;
			default:      prdata = '0;
		endcase
	end

endmodule

// File: src/htam_core.sv
// Alert evaluation and state (window flag, reference temperature).
// Depends on htam_pkg.
`timescale 1ns / 1ps

module htam_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  htam_pkg::htam_cfg_t   cfg,
	input  htam_pkg::htam_item_t  item,
	input  logic                  advance,
	output htam_pkg::htam_res_t   res
);
	import htam_pkg::*;

	logic                      window_widened_q;
	logic signed [TEMP_W-1:0]  ref_temp_q;

	logic signed [TEMP_W:0]    t_w;
	logic signed [TEMP_W:0]    sp_w;
	logic signed [TEMP_W:0]    width_w;
	logic signed [TEMP_W:0]    lo_w;
	logic signed [TEMP_W:0]    hi_w;
	logic signed [TEMP_W:0]    ref_w;
	logic signed [TEMP_W:0]    limit_w;
	logic                      in_window;
	logic                      narrow;
	logic                      below_ref;
	logic                      good;
	logic                      tracking;

	// Widen everything by one bit so the reference start value cannot wrap
	assign t_w     = {item.temperature[TEMP_W-1], item.temperature};
	assign sp_w    = {{(TEMP_W+1-SETPT_W){1'b0}}, cfg.set_temperature};
	assign width_w = {{(TEMP_W+1-WIN_W){1'b0}}, cfg.alert_window}
	               + (window_widened_q ?
	                  {{(TEMP_W+1-WIN_W){1'b0}}, cfg.alert_hysteresis} : '0);
	assign lo_w    = sp_w - width_w;
	assign hi_w    = sp_w + width_w;
	assign ref_w   = {ref_temp_q[TEMP_W-1], ref_temp_q};
	assign limit_w = ref_w + {{(TEMP_W+1-MARGIN_W){1'b0}}, cfg.rise_margin};

	assign in_window = (t_w > lo_w) && (t_w < hi_w);
	// width in use equals alert_window
	assign narrow    = !window_widened_q || (cfg.alert_hysteresis == '0);
	assign below_ref = t_w < ref_w;
	assign good      = !item.sensor_fault;
	assign tracking  = item.heater_on || item.calibrating;

	// Result of the current sample
	always_comb begin
		res.sensor_alert  = item.sensor_fault && item.ten_second_tick;
		res.reached_alert = good && in_window && narrow && item.heater_on;
		res.runaway_alert = good && !tracking && item.ten_second_tick
		                  && !below_ref && (t_w >= limit_w);
		res.force_sound   = res.sensor_alert || res.runaway_alert;
	end

	// State update, once per fault-free sample leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_widened_q <= 1'b0;
			ref_temp_q       <= REF_TEMP_RST;
		end else if (advance && good) begin
			window_widened_q <= in_window;
			if (tracking || (item.ten_second_tick && below_ref)) begin
				ref_temp_q <= item.temperature;
			end
		end
	end

endmodule

// File: src/htam_checker.sv
// Port-level checks for the heater temperature alert monitor, bound to the top.
// Depends on heater_temperature_alert_monitor_top_assert.svh.
`timescale 1ns / 1ps
`include "heater_temperature_alert_monitor_top_assert.svh"

module htam_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic sensor_alert,
	input logic reached_alert,
	input logic runaway_alert,
	input logic force_sound
);

	// force_sound follows the two alarms
	`HTAM_ASSERT_IMP(a_force_sound, clk, arst_n, out_valid, force_sound == (sensor_alert || runaway_alert))

	// a sensor alarm suppresses all other processing of its sample
	`HTAM_ASSERT_IMP(a_fault_excl, clk, arst_n, out_valid && sensor_alert, !reached_alert && !runaway_alert)

	// reached needs the heater on, runaway needs it off
	`HTAM_ASSERT_IMP(a_heat_excl, clk, arst_n, out_valid && reached_alert, !runaway_alert)

	// a stalled result beat holds
	`HTAM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({sensor_alert, reached_alert, runaway_alert, force_sound}))

endmodule

bind heater_temperature_alert_monitor_top htam_checker u_htam_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.sensor_alert  (sensor_alert),
	.reached_alert (reached_alert),
	.runaway_alert (runaway_alert),
	.force_sound   (force_sound)
);
